>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the path search core. All of them are
// clocked on aclk and are off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Consequent must hold in the same cycle as the antecedent.
`define GAPS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define GAPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GAPS_ASSERT_SAME(lbl, ante, cons, msg)
`define GAPS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/core/gaps_pkg.sv
// ----------------------------------------------------------------------------
// Grid path search package
// Widths, codes, cost constants and the per-cell node record shared by the
// path search core and its heuristic unit.
// ----------------------------------------------------------------------------
package gaps_pkg;

    localparam int COORD_W = 5;
    localparam int ADDR_W  = 2 * COORD_W;
    localparam int CELLS   = 1 << ADDR_W;
    localparam int COST_W  = 20;
    localparam int H_W     = 14;
    localparam int F_W     = COST_W + 1;
    localparam int LEN_W   = ADDR_W + 1;
    localparam int IDX_W   = 10;

    localparam int GRID_ROWS_DEF = 32;
    localparam int GRID_COLS_DEF = 32;

    localparam logic [COST_W-1:0] COST_MAX      = 20'hFFFFF;
    localparam logic [COST_W-1:0] STEP_STRAIGHT = 20'd256;
    localparam logic [COST_W-1:0] STEP_DIAG     = 20'd362;
    localparam logic [F_W-1:0]    F_NONE        = '1;

    localparam logic [COORD_W-1:0] START_ROW_RST = 5'd1;
    localparam logic [COORD_W-1:0] START_COL_RST = 5'd1;
    localparam logic [COORD_W-1:0] GOAL_ROW_RST  = 5'd28;
    localparam logic [COORD_W-1:0] GOAL_COL_RST  = 5'd23;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_READ   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        REG_START_ROW = 2'd0,
        REG_START_COL = 2'd1,
        REG_GOAL_ROW  = 2'd2,
        REG_GOAL_COL  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic              is_open;
        logic              is_closed;
        logic [COST_W-1:0] g;
        logic [H_W-1:0]    h;
        logic [ADDR_W-1:0] parent;
    } node_t;

endpackage

>>> rtl/core/gaps_heur.sv
// ----------------------------------------------------------------------------
// Heuristic unit
// Rounded Q8 Euclidean distance from a cell to the goal, computed with a
// digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module gaps_heur (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [gaps_pkg::COORD_W-1:0]  row,
    input  logic [gaps_pkg::COORD_W-1:0]  col,
    input  logic [gaps_pkg::COORD_W-1:0]  goal_row,
    input  logic [gaps_pkg::COORD_W-1:0]  goal_col,
    output logic                          busy,
    output logic [gaps_pkg::H_W-1:0]      h_value
);

    localparam int RAD_W = 28;
    localparam int ITERS = 14;

    logic                 busy_reg, busy_next;
    logic                 fin_reg, fin_next;
    logic [3:0]           iter_reg, iter_next;
    logic [RAD_W-1:0]     rem_reg, rem_next;
    logic [RAD_W-1:0]     root_reg, root_next;
    logic [RAD_W-1:0]     bit_reg, bit_next;
    logic [gaps_pkg::H_W-1:0] h_reg, h_next;

    logic [5:0]  dr, dc;
    logic [4:0]  adr, adc;
    logic [10:0] d2;
    logic [RAD_W-1:0] trial;

    always_comb begin
        dr  = {1'b0, row} - {1'b0, goal_row};
        dc  = {1'b0, col} - {1'b0, goal_col};
        adr = dr[5] ? 5'(-dr) : dr[4:0];
        adc = dc[5] ? 5'(-dc) : dc[4:0];
        d2  = (11'(adr) * 11'(adr)) + (11'(adc) * 11'(adc));
        trial = root_reg + bit_reg;

        busy_next = busy_reg;
        fin_next  = fin_reg;
        iter_next = iter_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        h_next    = h_reg;

        if (start) begin
            busy_next = 1'b1;
            fin_next  = 1'b0;
            iter_next = '0;
            rem_next  = RAD_W'({d2, 16'h0000});
            root_next = '0;
            bit_next  = RAD_W'(1) << (2 * (ITERS - 1));
        end else if (busy_reg && fin_reg) begin
            // Round to nearest: bump when the remainder exceeds the root.
            h_next    = gaps_pkg::H_W'(root_reg) + gaps_pkg::H_W'(rem_reg > root_reg);
            busy_next = 1'b0;
            fin_next  = 1'b0;
        end else if (busy_reg) begin
            if (rem_reg >= trial) begin
                rem_next  = rem_reg - trial;
                root_next = (root_reg >> 1) + bit_reg;
            end else begin
                root_next = root_reg >> 1;
            end
            bit_next  = bit_reg >> 2;
            iter_next = iter_reg + 4'd1;
            if (iter_reg == 4'(ITERS - 1)) begin
                fin_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
        end
        iter_reg <= iter_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        h_reg    <= h_next;
    end

    assign busy    = busy_reg;
    assign h_value = h_reg;

endmodule

>>> rtl/core/grid_astar_path_search_core.sv
// ----------------------------------------------------------------------------
// Grid A* path search core
// 8-connected A* search over an occupancy grid held in on-chip memory, with
// map loading, search and path read-back on one command channel.
// ----------------------------------------------------------------------------
// After reset the core marks every map cell blocked in a sweep over the map
// and accepts no beat during that pass; configuration writes are taken anyway.
// Map load and path read beats are taken one per cycle unless a pending path
// read waits on a full output register; a path read passes its result beat
// through the list read register and then the output register, and a new beat
// is accepted while an earlier result still waits on m_ready. A search beat
// holds s_ready low until the search finishes and its result beat is loaded
// into the output register. The search first clears the open and closed marks
// in a pass over the node memory; then each expansion scans the open list for
// the least f (one list read and one node read per entry, pipelined), closes
// the gap in the list behind the winner, checks each neighbor, and waits while
// the square root unit forms the heuristic of each newly opened neighbor.
// Tracing the path back reads the parent of each cell in turn.
// Cells are addressed as {row, col}; the start, the goal, the current cell
// and neighbors are never on the border of the grid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_astar_path_search_core #(
    parameter int GRID_ROWS = gaps_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = gaps_pkg::GRID_COLS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Command channel.
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_command,
    input  logic [gaps_pkg::COORD_W-1:0]   s_cell_row,
    input  logic [gaps_pkg::COORD_W-1:0]   s_cell_col,
    input  logic                           s_blocked,
    input  logic [gaps_pkg::IDX_W-1:0]     s_path_index,
    // Result channel.
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_found,
    output logic [gaps_pkg::LEN_W-1:0]     m_path_length,
    output logic [gaps_pkg::COST_W-1:0]    m_path_cost,
    output logic [gaps_pkg::COORD_W-1:0]   m_out_row,
    output logic [gaps_pkg::COORD_W-1:0]   m_out_col,
    // Configuration write port.
    input  logic                           cfg_wr_en,
    input  logic [1:0]                     cfg_wr_index,
    input  logic [gaps_pkg::COORD_W-1:0]   cfg_wr_data
);

    localparam int AW = gaps_pkg::ADDR_W;
    localparam int CW = gaps_pkg::COORD_W;
    localparam int LW = gaps_pkg::LEN_W;
    localparam int GW = gaps_pkg::COST_W;
    localparam int FW = gaps_pkg::F_W;

    // Last row and column index that may hold a node.
    localparam logic [CW:0] ROW_LAST = (CW+1)'(GRID_ROWS - 2);
    localparam logic [CW:0] COL_LAST = (CW+1)'(GRID_COLS - 2);
    localparam logic [CW:0] ROW_CNT  = (CW+1)'(GRID_ROWS);
    localparam logic [CW:0] COL_CNT  = (CW+1)'(GRID_COLS);
    localparam logic [LW-1:0] CELL_CNT = LW'(gaps_pkg::CELLS);

    typedef enum logic [15:0] {
        ST_INIT    = 16'h0001,
        ST_IDLE    = 16'h0002,
        ST_CHK_S   = 16'h0004,
        ST_CHK_G   = 16'h0008,
        ST_CHK_E   = 16'h0010,
        ST_CLEAR   = 16'h0020,
        ST_SEED    = 16'h0040,
        ST_SCAN    = 16'h0080,
        ST_PICK    = 16'h0100,
        ST_SHIFT   = 16'h0200,
        ST_NB_RD   = 16'h0400,
        ST_NB_EV   = 16'h0800,
        ST_NB_H    = 16'h1000,
        ST_PATH_WR = 16'h2000,
        ST_PATH_RD = 16'h4000,
        ST_DONE    = 16'h8000
    } state_t;

    // ------------------------------------------------------------------------
    // Memories. The map holds one blocked bit per cell, the node memory the
    // search record of each cell, and the list memory the open list during a
    // search and the traced path after it.
    // ------------------------------------------------------------------------
    logic              map_mem  [gaps_pkg::CELLS];
    gaps_pkg::node_t   node_mem [gaps_pkg::CELLS];
    logic [AW-1:0]     list_mem [gaps_pkg::CELLS];

    logic              map_we, map_re, map_wdata;
    logic [AW-1:0]     map_waddr, map_raddr;
    logic              map_rd_reg;

    logic              node_we, node_re;
    logic [AW-1:0]     node_waddr, node_raddr;
    gaps_pkg::node_t   node_wdata;
    gaps_pkg::node_t   node_rd_reg;

    logic              list_we, list_re;
    logic [AW-1:0]     list_waddr, list_raddr, list_wdata;
    logic [AW-1:0]     list_rd_reg;

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (map_re) begin
            map_rd_reg <= map_mem[map_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (node_re) begin
            node_rd_reg <= node_mem[node_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (list_we) begin
            list_mem[list_waddr] <= list_wdata;
        end
        if (list_re) begin
            list_rd_reg <= list_mem[list_raddr];
        end
    end

    // ------------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------------
    state_t            state_reg, state_next;
    logic [CW-1:0]     start_row_reg, start_row_next;
    logic [CW-1:0]     start_col_reg, start_col_next;
    logic [CW-1:0]     goal_row_reg, goal_row_next;
    logic [CW-1:0]     goal_col_reg, goal_col_next;
    logic [AW-1:0]     sweep_reg, sweep_next;
    logic              start_blk_reg, start_blk_next;
    logic [LW-1:0]     cnt_reg, cnt_next;
    logic [LW-1:0]     k_reg, k_next;
    logic              a_v_reg, a_v_next;
    logic [AW-1:0]     a_k_reg, a_k_next;
    logic              b_v_reg, b_v_next;
    logic [AW-1:0]     b_k_reg, b_k_next;
    logic [AW-1:0]     b_id_reg, b_id_next;
    logic [FW-1:0]     best_f_reg, best_f_next;
    logic [AW-1:0]     best_k_reg, best_k_next;
    logic [AW-1:0]     best_id_reg, best_id_next;
    gaps_pkg::node_t   best_node_reg, best_node_next;
    logic [2:0]        nb_idx_reg, nb_idx_next;
    logic [AW-1:0]     nb_id_reg, nb_id_next;
    logic              diag_reg, diag_next;
    logic [GW-1:0]     tg_reg, tg_next;
    logic [LW-1:0]     pc_reg, pc_next;
    logic [AW-1:0]     pcell_reg, pcell_next;
    logic              found_reg, found_next;
    logic [LW-1:0]     path_cnt_reg, path_cnt_next;
    logic [GW-1:0]     cost_reg, cost_next;
    logic              p1_v_reg, p1_v_next;
    logic              p1_ok_reg, p1_ok_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_found_reg, m_found_next;
    logic [LW-1:0]     m_len_reg, m_len_next;
    logic [GW-1:0]     m_cost_reg, m_cost_next;
    logic [CW-1:0]     m_row_reg, m_row_next;
    logic [CW-1:0]     m_col_reg, m_col_next;

    // Heuristic unit hookup.
    logic              h_start, h_busy;
    logic [CW-1:0]     h_row, h_col;
    logic [gaps_pkg::H_W-1:0] h_value;

    gaps_heur u_heur (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (h_start),
        .row      (h_row),
        .col      (h_col),
        .goal_row (goal_row_reg),
        .goal_col (goal_col_reg),
        .busy     (h_busy),
        .h_value  (h_value)
    );

    // ------------------------------------------------------------------------
    // Next-state logic.
    // ------------------------------------------------------------------------
    logic              out_free, s_fire;
    logic [AW-1:0]     s_id, g_id;
    logic              s_ok, g_ok, start_on_grid, goal_on_grid;
    logic [FW-1:0]     f_val;
    logic [CW:0]       cur_r, cur_c, nr, nc;
    logic              nb_in, nb_diag;
    logic [FW-1:0]     tg_sum;
    logic [GW-1:0]     tg_sat;
    logic              nb_adv, scan_go;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && (!p1_v_reg || out_free);
    assign s_fire   = s_valid && s_ready;
    assign s_id     = {start_row_reg, start_col_reg};
    assign g_id     = {goal_row_reg, goal_col_reg};

    always_comb begin
        start_on_grid = ({1'b0, start_row_reg} >= (CW+1)'(1))
                     && ({1'b0, start_row_reg} <= ROW_LAST)
                     && ({1'b0, start_col_reg} >= (CW+1)'(1))
                     && ({1'b0, start_col_reg} <= COL_LAST);
        goal_on_grid  = ({1'b0, goal_row_reg} >= (CW+1)'(1))
                     && ({1'b0, goal_row_reg} <= ROW_LAST)
                     && ({1'b0, goal_col_reg} >= (CW+1)'(1))
                     && ({1'b0, goal_col_reg} <= COL_LAST);
        s_ok = start_on_grid && !start_blk_reg;
        g_ok = goal_on_grid && !map_rd_reg;

        f_val = {1'b0, node_rd_reg.g} + FW'(node_rd_reg.h);

        // Neighbor offsets in row-major order, the center skipped.
        cur_r = {1'b0, best_id_reg[AW-1:CW]};
        cur_c = {1'b0, best_id_reg[CW-1:0]};
        case (nb_idx_reg)
            3'd0: begin nr = cur_r - 1'b1; nc = cur_c - 1'b1; end
            3'd1: begin nr = cur_r - 1'b1; nc = cur_c;        end
            3'd2: begin nr = cur_r - 1'b1; nc = cur_c + 1'b1; end
            3'd3: begin nr = cur_r;        nc = cur_c - 1'b1; end
            3'd4: begin nr = cur_r;        nc = cur_c + 1'b1; end
            3'd5: begin nr = cur_r + 1'b1; nc = cur_c - 1'b1; end
            3'd6: begin nr = cur_r + 1'b1; nc = cur_c;        end
            3'd7: begin nr = cur_r + 1'b1; nc = cur_c + 1'b1; end
            default: begin nr = cur_r; nc = cur_c; end
        endcase
        nb_diag = (nb_idx_reg == 3'd0) || (nb_idx_reg == 3'd2)
               || (nb_idx_reg == 3'd5) || (nb_idx_reg == 3'd7);
        nb_in   = (nr != '0) && (nr <= ROW_LAST) && (nc != '0) && (nc <= COL_LAST);

        tg_sum = {1'b0, best_node_reg.g}
               + FW'(diag_reg ? gaps_pkg::STEP_DIAG : gaps_pkg::STEP_STRAIGHT);
        tg_sat = (tg_sum > FW'(gaps_pkg::COST_MAX)) ? gaps_pkg::COST_MAX : tg_sum[GW-1:0];
    end

    always_comb begin
        state_next     = state_reg;
        start_row_next = start_row_reg;
        start_col_next = start_col_reg;
        goal_row_next  = goal_row_reg;
        goal_col_next  = goal_col_reg;
        sweep_next     = sweep_reg;
        start_blk_next = start_blk_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        a_v_next       = 1'b0;
        a_k_next       = a_k_reg;
        b_v_next       = 1'b0;
        b_k_next       = b_k_reg;
        b_id_next      = b_id_reg;
        best_f_next    = best_f_reg;
        best_k_next    = best_k_reg;
        best_id_next   = best_id_reg;
        best_node_next = best_node_reg;
        nb_idx_next    = nb_idx_reg;
        nb_id_next     = nb_id_reg;
        diag_next      = diag_reg;
        tg_next        = tg_reg;
        pc_next        = pc_reg;
        pcell_next     = pcell_reg;
        found_next     = found_reg;
        path_cnt_next  = path_cnt_reg;
        cost_next      = cost_reg;
        p1_v_next      = p1_v_reg;
        p1_ok_next     = p1_ok_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_found_next   = m_found_reg;
        m_len_next     = m_len_reg;
        m_cost_next    = m_cost_reg;
        m_row_next     = m_row_reg;
        m_col_next     = m_col_reg;

        map_we = 1'b0; map_waddr = s_id; map_wdata = 1'b1;
        map_re = 1'b0; map_raddr = s_id;
        node_we = 1'b0; node_waddr = s_id; node_wdata = '0;
        node_re = 1'b0; node_raddr = s_id;
        list_we = 1'b0; list_waddr = '0; list_wdata = s_id;
        list_re = 1'b0; list_raddr = '0;

        h_start = 1'b0;
        h_row   = nb_id_reg[AW-1:CW];
        h_col   = nb_id_reg[CW-1:0];
        nb_adv  = 1'b0;
        scan_go = 1'b0;

        if (cfg_wr_en) begin
            case (cfg_wr_index)
                gaps_pkg::REG_START_ROW: start_row_next = cfg_wr_data;
                gaps_pkg::REG_START_COL: start_col_next = cfg_wr_data;
                gaps_pkg::REG_GOAL_ROW:  goal_row_next  = cfg_wr_data;
                gaps_pkg::REG_GOAL_COL:  goal_col_next  = cfg_wr_data;
                default: ;
            endcase
        end

        // A pending path read moves into the output register when it is free.
        if (p1_v_reg && out_free) begin
            p1_v_next    = 1'b0;
            m_valid_next = 1'b1;
            m_found_next = found_reg;
            m_len_next   = path_cnt_reg;
            m_cost_next  = cost_reg;
            m_row_next   = p1_ok_reg ? list_rd_reg[AW-1:CW] : '0;
            m_col_next   = p1_ok_reg ? list_rd_reg[CW-1:0] : '0;
        end

        case (state_reg)
            ST_INIT: begin
                map_we     = 1'b1;
                map_waddr  = sweep_reg;
                map_wdata  = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (s_fire) begin
                    case (s_command)
                        gaps_pkg::CMD_LOAD: begin
                            if (({1'b0, s_cell_row} < ROW_CNT)
                                    && ({1'b0, s_cell_col} < COL_CNT)) begin
                                map_we    = 1'b1;
                                map_waddr = {s_cell_row, s_cell_col};
                                map_wdata = s_blocked;
                            end
                        end
                        gaps_pkg::CMD_SEARCH: begin
                            found_next    = 1'b0;
                            path_cnt_next = '0;
                            cost_next     = '0;
                            cnt_next      = '0;
                            state_next    = ST_CHK_S;
                        end
                        gaps_pkg::CMD_READ: begin
                            list_re    = 1'b1;
                            list_raddr = s_path_index;
                            p1_v_next  = 1'b1;
                            p1_ok_next = ({1'b0, s_path_index} < path_cnt_reg);
                        end
                        default: ;
                    endcase
                end
            end

            ST_CHK_S: begin
                map_re     = 1'b1;
                map_raddr  = s_id;
                state_next = ST_CHK_G;
            end

            ST_CHK_G: begin
                start_blk_next = map_rd_reg;
                map_re         = 1'b1;
                map_raddr      = g_id;
                state_next     = ST_CHK_E;
            end

            ST_CHK_E: begin
                if (s_ok && g_ok) begin
                    // The start heuristic is formed while the marks are cleared.
                    h_start    = 1'b1;
                    h_row      = start_row_reg;
                    h_col      = start_col_reg;
                    sweep_next = '0;
                    state_next = ST_CLEAR;
                end else begin
                    state_next = ST_DONE;
                end
            end

            ST_CLEAR: begin
                node_we    = 1'b1;
                node_waddr = sweep_reg;
                node_wdata = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == '1) begin
                    state_next = ST_SEED;
                end
            end

            ST_SEED: begin
                if (!h_busy) begin
                    node_we    = 1'b1;
                    node_waddr = s_id;
                    node_wdata = '{is_open: 1'b1, is_closed: 1'b0, g: '0,
                                   h: h_value, parent: s_id};
                    list_we    = 1'b1;
                    list_waddr = '0;
                    list_wdata = s_id;
                    cnt_next   = LW'(1);
                    scan_go    = 1'b1;
                end
            end

            ST_SCAN: begin
                // Three-deep pipeline: list entry, node record, f compare.
                if (k_reg < cnt_reg) begin
                    list_re    = 1'b1;
                    list_raddr = k_reg[AW-1:0];
                    a_v_next   = 1'b1;
                    a_k_next   = k_reg[AW-1:0];
                    k_next     = k_reg + 1'b1;
                end
                if (a_v_reg) begin
                    node_re    = 1'b1;
                    node_raddr = list_rd_reg;
                    b_v_next   = 1'b1;
                    b_k_next   = a_k_reg;
                    b_id_next  = list_rd_reg;
                end
                if (b_v_reg && (f_val < best_f_reg)) begin
                    best_f_next    = f_val;
                    best_k_next    = b_k_reg;
                    best_id_next   = b_id_reg;
                    best_node_next = node_rd_reg;
                end
                if ((k_reg >= cnt_reg) && !a_v_reg && !b_v_reg) begin
                    state_next = ST_PICK;
                end
            end

            ST_PICK: begin
                if (best_id_reg == g_id) begin
                    pc_next    = '0;
                    pcell_next = best_id_reg;
                    state_next = ST_PATH_WR;
                end else begin
                    node_we    = 1'b1;
                    node_waddr = best_id_reg;
                    node_wdata = best_node_reg;
                    node_wdata.is_open   = 1'b0;
                    node_wdata.is_closed = 1'b1;
                    k_next     = LW'(best_k_reg) + 1'b1;
                    state_next = ST_SHIFT;
                end
            end

            ST_SHIFT: begin
                // Entries behind the winner move down one place.
                if (k_reg < cnt_reg) begin
                    list_re    = 1'b1;
                    list_raddr = k_reg[AW-1:0];
                    a_v_next   = 1'b1;
                    a_k_next   = k_reg[AW-1:0];
                    k_next     = k_reg + 1'b1;
                end
                if (a_v_reg) begin
                    list_we    = 1'b1;
                    list_waddr = a_k_reg - 1'b1;
                    list_wdata = list_rd_reg;
                end
                if ((k_reg >= cnt_reg) && !a_v_reg) begin
                    cnt_next    = cnt_reg - 1'b1;
                    nb_idx_next = '0;
                    state_next  = ST_NB_RD;
                end
            end

            ST_NB_RD: begin
                if (nb_in) begin
                    map_re     = 1'b1;
                    map_raddr  = {nr[CW-1:0], nc[CW-1:0]};
                    node_re    = 1'b1;
                    node_raddr = {nr[CW-1:0], nc[CW-1:0]};
                    nb_id_next = {nr[CW-1:0], nc[CW-1:0]};
                    diag_next  = nb_diag;
                    state_next = ST_NB_EV;
                end else begin
                    nb_adv = 1'b1;
                end
            end

            ST_NB_EV: begin
                if (!map_rd_reg && !node_rd_reg.is_closed) begin
                    if (!node_rd_reg.is_open) begin
                        h_start    = 1'b1;
                        tg_next    = tg_sat;
                        state_next = ST_NB_H;
                    end else begin
                        if (tg_sat < node_rd_reg.g) begin
                            node_we    = 1'b1;
                            node_waddr = nb_id_reg;
                            node_wdata = '{is_open: 1'b1, is_closed: 1'b0, g: tg_sat,
                                           h: node_rd_reg.h, parent: best_id_reg};
                        end
                        nb_adv = 1'b1;
                    end
                end else begin
                    nb_adv = 1'b1;
                end
            end

            ST_NB_H: begin
                if (!h_busy) begin
                    node_we    = 1'b1;
                    node_waddr = nb_id_reg;
                    node_wdata = '{is_open: (cnt_reg < CELL_CNT), is_closed: 1'b0,
                                   g: tg_reg, h: h_value, parent: best_id_reg};
                    if (cnt_reg < CELL_CNT) begin
                        list_we    = 1'b1;
                        list_waddr = cnt_reg[AW-1:0];
                        list_wdata = nb_id_reg;
                        cnt_next   = cnt_reg + 1'b1;
                    end
                    nb_adv = 1'b1;
                end
            end

            ST_PATH_WR: begin
                list_we    = 1'b1;
                list_waddr = pc_reg[AW-1:0];
                list_wdata = pcell_reg;
                pc_next    = pc_reg + 1'b1;
                if ((pcell_reg == s_id) || ((pc_reg + 1'b1) == CELL_CNT)) begin
                    found_next    = 1'b1;
                    path_cnt_next = pc_reg + 1'b1;
                    cost_next     = best_node_reg.g;
                    state_next    = ST_DONE;
                end else begin
                    node_re    = 1'b1;
                    node_raddr = pcell_reg;
                    state_next = ST_PATH_RD;
                end
            end

            ST_PATH_RD: begin
                pcell_next = node_rd_reg.parent;
                state_next = ST_PATH_WR;
            end

            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_found_next = found_reg;
                    m_len_next   = path_cnt_reg;
                    m_cost_next  = cost_reg;
                    m_row_next   = '0;
                    m_col_next   = '0;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // After the last neighbor either scan again or give up on an empty list.
        if (nb_adv) begin
            if (nb_idx_reg == 3'd7) begin
                if (cnt_reg != '0) begin
                    scan_go = 1'b1;
                end else begin
                    state_next = ST_DONE;
                end
            end else begin
                nb_idx_next = nb_idx_reg + 1'b1;
                state_next  = ST_NB_RD;
            end
        end

        if (scan_go) begin
            k_next      = '0;
            a_v_next    = 1'b0;
            b_v_next    = 1'b0;
            best_f_next = gaps_pkg::F_NONE;
            state_next  = ST_SCAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            start_row_reg <= gaps_pkg::START_ROW_RST;
            start_col_reg <= gaps_pkg::START_COL_RST;
            goal_row_reg  <= gaps_pkg::GOAL_ROW_RST;
            goal_col_reg  <= gaps_pkg::GOAL_COL_RST;
            sweep_reg     <= '0;
            cnt_reg       <= '0;
            a_v_reg       <= 1'b0;
            b_v_reg       <= 1'b0;
            found_reg     <= 1'b0;
            path_cnt_reg  <= '0;
            cost_reg      <= '0;
            p1_v_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            start_row_reg <= start_row_next;
            start_col_reg <= start_col_next;
            goal_row_reg  <= goal_row_next;
            goal_col_reg  <= goal_col_next;
            sweep_reg     <= sweep_next;
            cnt_reg       <= cnt_next;
            a_v_reg       <= a_v_next;
            b_v_reg       <= b_v_next;
            found_reg     <= found_next;
            path_cnt_reg  <= path_cnt_next;
            cost_reg      <= cost_next;
            p1_v_reg      <= p1_v_next;
            m_valid_reg   <= m_valid_next;
        end
        start_blk_reg <= start_blk_next;
        k_reg         <= k_next;
        a_k_reg       <= a_k_next;
        b_k_reg       <= b_k_next;
        b_id_reg      <= b_id_next;
        best_f_reg    <= best_f_next;
        best_k_reg    <= best_k_next;
        best_id_reg   <= best_id_next;
        best_node_reg <= best_node_next;
        nb_idx_reg    <= nb_idx_next;
        nb_id_reg     <= nb_id_next;
        diag_reg      <= diag_next;
        tg_reg        <= tg_next;
        pc_reg        <= pc_next;
        pcell_reg     <= pcell_next;
        p1_ok_reg     <= p1_ok_next;
        m_found_reg   <= m_found_next;
        m_len_reg     <= m_len_next;
        m_cost_reg    <= m_cost_next;
        m_row_reg     <= m_row_next;
        m_col_reg     <= m_col_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_path_length = m_len_reg;
    assign m_path_cost   = m_cost_reg;
    assign m_out_row     = m_row_reg;
    assign m_out_col     = m_col_reg;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    `GAPS_ASSERT_SAME(a_heur_free, h_start, !h_busy, "heuristic unit started while busy")
    `GAPS_ASSERT_SAME(a_found_len, found_reg, path_cnt_reg != '0, "found with an empty path")
    `GAPS_ASSERT_NEXT(a_search_hold, s_fire && (s_command == gaps_pkg::CMD_SEARCH), !s_ready, "search beat did not stall the channel")
    `GAPS_ASSERT_NEXT(a_read_hold, p1_v_reg && !out_free, p1_v_reg, "pending path read lost")

endmodule
